@@ rtl/core/brp_pkg.sv @@
`timescale 1ns / 1ps

package brp_pkg;

  // Line geometry
  localparam int MAX_LINE_WIDTH = 8192;
  localparam int COL_W          = $clog2(MAX_LINE_WIDTH);
  localparam int LW_W           = 14;
  localparam int MIN_LINE_WIDTH = 4;

  // Configuration register indexes
  localparam logic [1:0] REG_BAYER_PATTERN = 2'd0;
  localparam logic [1:0] REG_SAMPLE_FORMAT = 2'd1;
  localparam logic [1:0] REG_LINE_WIDTH    = 2'd2;

  // Output packing formats
  localparam logic [1:0] FMT_RAW8  = 2'd0;
  localparam logic [1:0] FMT_RAW10 = 2'd1;
  localparam logic [1:0] FMT_RAW12 = 2'd2;
  localparam logic [1:0] FMT_RAW16 = 2'd3;

  // Reset values of the configuration registers
  localparam logic [1:0]      RST_BAYER_PATTERN = 2'd0;
  localparam logic [1:0]      RST_SAMPLE_FORMAT = FMT_RAW8;
  localparam logic [LW_W-1:0] RST_LINE_WIDTH    = LW_W'(1920);

  typedef enum logic [1:0] {
    CH_RED,
    CH_GREEN,
    CH_BLUE
  } chan_t;

  // Channel kept per {pattern, row parity, column parity}
  localparam chan_t CHAN_SEL [0:15] = '{
    CH_BLUE,  CH_GREEN, CH_GREEN, CH_RED,    // BGGR
    CH_GREEN, CH_BLUE,  CH_RED,   CH_GREEN,  // GBRG
    CH_RED,   CH_GREEN, CH_GREEN, CH_BLUE,   // RGGB
    CH_GREEN, CH_RED,   CH_BLUE,  CH_GREEN   // GRBG
  };

  typedef struct packed {
    logic [7:0] red_value;
    logic [7:0] green_value;
    logic [7:0] blue_value;
    logic       frame_start;
  } pixel_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } raw_byte_t;

  typedef struct packed {
    logic [1:0]      bayer_pattern;
    logic [1:0]      sample_format;
    logic [LW_W-1:0] line_width;
  } cfg_t;

  // Bytes caused by one pixel: byte0 always, byte1 when two is set
  typedef struct packed {
    logic       two;
    logic [7:0] byte0;
    logic [7:0] byte1;
  } pack_res_t;

endpackage

@@ rtl/core/brp_in_reg.sv @@
`timescale 1ns / 1ps

module brp_in_reg (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  brp_pkg::pixel_t in_data,
  output logic            pix_valid,
  output brp_pkg::pixel_t pix_data,
  input  logic            pix_take
);
  import brp_pkg::*;

  logic   valid;
  pixel_t data;
  logic   load;

  // Stall only while a held pixel cannot move on this cycle
  assign in_stall  = valid && !pix_take;
  assign load      = in_valid && !in_stall;
  assign pix_valid = valid;
  assign pix_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (pix_take) begin
      valid <= 1'b0;
    end
    if (load) begin
      data <= in_data;
    end
  end

endmodule

@@ rtl/core/brp_pack.sv @@
`timescale 1ns / 1ps

module brp_pack (
  input  logic               clk,
  input  logic               rst,
  input  brp_pkg::cfg_t      cfg,
  input  brp_pkg::pixel_t    pix,
  input  logic               advance,
  output brp_pkg::pack_res_t res
);
  import brp_pkg::*;

  logic [COL_W-1:0] column_count;
  logic             row_is_odd;
  logic [7:0]       pending_low_bits;

  logic [COL_W-1:0] column_count_next;
  logic             row_is_odd_next;
  logic [7:0]       pending_low_bits_next;

  logic [COL_W-1:0] col;
  logic             row;
  logic [7:0]       pend;
  logic [7:0]       sample;
  logic [9:0]       v10;
  logic [11:0]      v12;
  logic [7:0]       pend_or;
  logic [7:0]       pend_pkt;
  logic [LW_W-1:0]  width;
  logic [LW_W-1:0]  col_inc;
  chan_t            chan;

  // Position as seen by this pixel; a frame start clears it first
  always_comb begin
    col  = pix.frame_start ? '0 : column_count;
    row  = pix.frame_start ? 1'b0 : row_is_odd;
    pend = pix.frame_start ? 8'h00 : pending_low_bits;
  end

  // Bayer channel select
  always_comb begin
    chan = CHAN_SEL[{cfg.bayer_pattern, row, col[0]}];
    case (chan)
      CH_RED:   sample = pix.red_value;
      CH_GREEN: sample = pix.green_value;
      CH_BLUE:  sample = pix.blue_value;
      default:  sample = pix.green_value;
    endcase
  end

  // Byte packing per format
  always_comb begin
    v10      = {sample, 2'b00};
    v12      = {sample, 4'h0};
    pend_or  = pend | (8'(v10[1:0]) << {col[1:0], 1'b0});
    pend_pkt = {v12[3:0], pend[3:0]};
    res.two   = 1'b0;
    res.byte0 = sample;
    res.byte1 = 8'h00;
    pending_low_bits_next = pend;
    case (cfg.sample_format)
      FMT_RAW8: begin
        res.byte0 = sample;
      end
      FMT_RAW10: begin
        res.byte0 = v10[9:2];
        if (col[1:0] == 2'b11) begin
          res.two   = 1'b1;
          res.byte1 = pend_or;
          pending_low_bits_next = 8'h00;
        end else begin
          pending_low_bits_next = pend_or;
        end
      end
      FMT_RAW12: begin
        res.byte0 = v12[11:4];
        if (!col[0]) begin
          pending_low_bits_next = {4'h0, v12[3:0]};
        end else begin
          res.two   = 1'b1;
          res.byte1 = pend_pkt;
          pending_low_bits_next = 8'h00;
        end
      end
      default: begin
        res.two   = 1'b1;
        res.byte0 = 8'h00;
        res.byte1 = sample;
      end
    endcase
  end

  // Line width clamp and column advance
  always_comb begin
    if (cfg.line_width < LW_W'(MIN_LINE_WIDTH)) begin
      width = LW_W'(MIN_LINE_WIDTH);
    end else if (cfg.line_width > LW_W'(MAX_LINE_WIDTH)) begin
      width = LW_W'(MAX_LINE_WIDTH);
    end else begin
      width = cfg.line_width;
    end
    col_inc = LW_W'(col) + LW_W'(1);
    if (col_inc >= width) begin
      column_count_next = '0;
      row_is_odd_next   = !row;
    end else begin
      column_count_next = col_inc[COL_W-1:0];
      row_is_odd_next   = row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count     <= '0;
      row_is_odd       <= 1'b0;
      pending_low_bits <= 8'h00;
    end else if (advance) begin
      column_count     <= column_count_next;
      row_is_odd       <= row_is_odd_next;
      pending_low_bits <= (col_inc >= width) ? 8'h00 : pending_low_bits_next;
    end
  end

endmodule

@@ rtl/core/brp_out_ser.sv @@
`timescale 1ns / 1ps

module brp_out_ser (
  input  logic               clk,
  input  logic               rst,
  input  brp_pkg::pack_res_t res,
  input  logic               res_valid,
  output logic               res_ready,
  output logic               out_valid,
  input  logic               out_stall,
  output brp_pkg::raw_byte_t out_data
);
  import brp_pkg::*;

  logic       valid;
  logic       has_second;
  raw_byte_t  cur;
  logic [7:0] second;
  logic       out_fire;
  logic       load;

  assign out_fire  = valid && !out_stall;
  // A new pixel may land once the last byte of the current one leaves
  assign res_ready = !valid || (out_fire && !has_second);
  assign load      = res_valid && res_ready;
  assign out_valid = valid;
  assign out_data  = cur;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= 1'b0;
      has_second <= 1'b0;
    end else if (load) begin
      valid      <= 1'b1;
      has_second <= res.two;
    end else if (out_fire) begin
      if (has_second) begin
        has_second <= 1'b0;
      end else begin
        valid <= 1'b0;
      end
    end
    // Byte payload
    if (load) begin
      cur.out_byte    <= res.byte0;
      cur.last_of_run <= !res.two;
      second          <= res.byte1;
    end else if (out_fire && has_second) begin
      cur.out_byte    <= second;
      cur.last_of_run <= 1'b1;
    end
  end

endmodule

@@ rtl/core/bayer_mosaic_raw_packer.sv @@
`timescale 1ns / 1ps

// Bayer mosaic raw packer.
// Input channel: one RGB pixel per transfer (in_valid / in_stall / in_data),
// in raster order; frame_start marks the first pixel of a frame and clears the
// column, row parity and packing state. Output channel: one byte per transfer
// (out_valid / out_stall / out_data); last_of_run flags the final byte that a
// pixel produced. Configuration: cfg_valid / cfg_ready / cfg_index / cfg_data,
// always ready; index 0 Bayer order, 1 sample format, 2 line width.
// Path: a pixel passes the input register, then the byte register, whose
// output drives out_data. Rate: one pixel per cycle for one-byte pixels while
// out_stall stays low; a pixel that yields two bytes holds the byte register
// until both have left the single byte-wide output port, and the next pixel
// waits. Raw8 yields one byte per pixel, raw16 two, raw10 five bytes per four
// pixels and raw12 three per two.
// Reset (rst, synchronous) empties both registers and returns configuration
// to BGGR, raw8 and 1920 pixels per line.
// When out_stall is high the current byte holds; the pipeline fills and
// in_stall rises once the input register also holds a pixel.
module bayer_mosaic_raw_packer (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  brp_pkg::pixel_t         in_data,
  output logic                    out_valid,
  input  logic                    out_stall,
  output brp_pkg::raw_byte_t      out_data,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [1:0]              cfg_index,
  input  logic [brp_pkg::LW_W-1:0] cfg_data
);
  import brp_pkg::*;

  cfg_t      cfg;
  logic      pix_valid;
  pixel_t    pix_data;
  logic      ser_ready;
  logic      advance;
  pack_res_t res;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bayer_pattern <= RST_BAYER_PATTERN;
      cfg.sample_format <= RST_SAMPLE_FORMAT;
      cfg.line_width    <= RST_LINE_WIDTH;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BAYER_PATTERN: cfg.bayer_pattern <= cfg_data[1:0];
        REG_SAMPLE_FORMAT: cfg.sample_format <= cfg_data[1:0];
        REG_LINE_WIDTH:    cfg.line_width    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign advance = pix_valid && ser_ready;

  brp_in_reg u_in_reg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .pix_valid (pix_valid),
    .pix_data  (pix_data),
    .pix_take  (advance)
  );

  brp_pack u_pack (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .pix     (pix_data),
    .advance (advance),
    .res     (res)
  );

  brp_out_ser u_out_ser (
    .clk       (clk),
    .rst       (rst),
    .res       (res),
    .res_valid (pix_valid),
    .res_ready (ser_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef NO_ASSERTIONS
  // Input stalls only because the byte register is occupied
  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with empty byte register");

  // A byte that is not last is followed at once by its partner
  a_second_ready: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !out_data.last_of_run) |=> out_valid)
    else $error("second byte of a pixel missing");

  // Reset leaves no byte on the output
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");
`endif

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import brp_pkg::*;

  // Mosaic orders as written to the pattern register
  localparam logic [1:0] PAT_BGGR = 2'd0;
  localparam logic [1:0] PAT_GBRG = 2'd1;
  localparam logic [1:0] PAT_RGGB = 2'd2;
  localparam logic [1:0] PAT_GRBG = 2'd3;
  // Index with no register behind it; writes there are dropped
  localparam logic [1:0] REG_UNUSED = 2'd3;

  localparam int IDLE_PCT    = 28;
  localparam int CYCLE_LIMIT = 300000;

  logic            clk;
  logic            rst = 1'b1;
  logic            in_valid = 1'b0;
  logic            in_stall;
  pixel_t          in_data = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  raw_byte_t       out_data;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic [1:0]      cfg_index = '0;
  logic [LW_W-1:0] cfg_data = '0;

  pixel_t    pending_pixels [$];
  raw_byte_t expected_bytes [$];
  bit        no_idle = 1'b0;
  int        errors = 0;
  int        cycles = 0;

  // Mirror of the packer: configuration and line position
  logic [1:0]      cur_pattern = RST_BAYER_PATTERN;
  logic [1:0]      cur_format  = RST_SAMPLE_FORMAT;
  logic [LW_W-1:0] cur_width   = RST_LINE_WIDTH;
  int              col_pos = 0;
  logic            row_odd = 1'b0;
  logic [7:0]      low_acc = '0;

  bayer_mosaic_raw_packer DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic void expect_byte(logic [7:0] b, logic last);
    raw_byte_t r;
    r.out_byte    = b;
    r.last_of_run = last;
    expected_bytes.push_back(r);
  endfunction

  // Work out the bytes one pixel produces and advance the line position
  function automatic void pack_pixel(pixel_t px);
    logic        is_green;
    logic        is_red;
    logic [7:0]  smp;
    logic [9:0]  s10;
    logic [11:0] s12;
    int          lim;
    if (px.frame_start) begin
      col_pos = 0;
      row_odd = 1'b0;
      low_acc = '0;
    end
    // Green sits on the checkerboard; red vs blue alternates by row
    is_green = (row_odd ^ col_pos[0]) != cur_pattern[0];
    is_red   = row_odd ^ cur_pattern[1];
    smp = is_green ? px.green_value : (is_red ? px.red_value : px.blue_value);
    s10 = {smp, 2'b00};
    s12 = {smp, 4'b0000};
    case (cur_format)
      FMT_RAW8: expect_byte(smp, 1'b1);
      FMT_RAW10: begin
        low_acc = low_acc | (8'(s10[1:0]) << (2 * col_pos[1:0]));
        if (col_pos[1:0] == 2'd3) begin
          expect_byte(s10[9:2], 1'b0);
          expect_byte(low_acc, 1'b1);
          low_acc = '0;
        end else begin
          expect_byte(s10[9:2], 1'b1);
        end
      end
      FMT_RAW12: begin
        if (!col_pos[0]) begin
          low_acc = {4'h0, s12[3:0]};
          expect_byte(s12[11:4], 1'b1);
        end else begin
          expect_byte(s12[11:4], 1'b0);
          expect_byte({s12[3:0], low_acc[3:0]}, 1'b1);
          low_acc = '0;
        end
      end
      default: begin
        expect_byte(8'h00, 1'b0);
        expect_byte(smp, 1'b1);
      end
    endcase
    // Out-of-range widths clamp to the legal span
    lim = int'(cur_width);
    if (lim < MIN_LINE_WIDTH) lim = MIN_LINE_WIDTH;
    if (lim > MAX_LINE_WIDTH) lim = MAX_LINE_WIDTH;
    if (col_pos + 1 >= lim) begin
      col_pos = 0;
      row_odd = ~row_odd;
      low_acc = '0;
    end else begin
      col_pos = col_pos + 1;
    end
  endfunction

  // Pixel driver: predict on each transfer, then offer the next pixel or idle
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) pack_pixel(in_data);
      if (!in_valid || !in_stall) begin
        if (pending_pixels.size() != 0 && (no_idle || $urandom_range(0, 99) >= IDLE_PCT)) begin
          in_data  <= pending_pixels.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Byte monitor: compare each transfer with the oldest expectation
  always @(posedge clk) begin
    raw_byte_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected byte %h last %b", $time, out_data.out_byte,
                   out_data.last_of_run);
          errors++;
        end else begin
          want = expected_bytes.pop_front();
          if (out_data.out_byte !== want.out_byte) begin
            $display("%0t: out_byte expected %h actual %h", $time, want.out_byte,
                     out_data.out_byte);
            errors++;
          end
          if (out_data.last_of_run !== want.last_of_run) begin
            $display("%0t: last_of_run expected %b actual %b", $time,
                     want.last_of_run, out_data.last_of_run);
            errors++;
          end
        end
      end
      out_stall <= !no_idle && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("bayer_mosaic_raw_packer regression: fail");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [LW_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_BAYER_PATTERN: cur_pattern = val[1:0];
      REG_SAMPLE_FORMAT: cur_format = val[1:0];
      REG_LINE_WIDTH:    cur_width = val;
      default: ;
    endcase
  endtask

  // All pixels taken, all bytes seen, then a short pause for the pipeline
  task automatic wait_idle();
    do @(posedge clk);
    while (pending_pixels.size() != 0 || in_valid || expected_bytes.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  function automatic void queue_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                      logic fs);
    pixel_t px;
    px.red_value   = r;
    px.green_value = g;
    px.blue_value  = b;
    px.frame_start = fs;
    pending_pixels.push_back(px);
  endfunction

  initial begin
    int n_items;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset config, field extremes
    queue_pixel(8'h00, 8'h00, 8'h00, 1'b1);
    queue_pixel(8'hff, 8'hff, 8'hff, 1'b0);
    wait_idle();

    // Raw10, width not a multiple of four: last group cut short
    write_reg(REG_BAYER_PATTERN, PAT_GRBG);
    write_reg(REG_SAMPLE_FORMAT, FMT_RAW10);
    write_reg(REG_LINE_WIDTH, LW_W'(5));
    queue_pixel(8'hff, 8'h00, 8'h81, 1'b1);
    queue_pixel(8'h00, 8'hff, 8'h7e, 1'b0);
    queue_pixel(8'h81, 8'h7e, 8'hff, 1'b0);
    queue_pixel(8'h7e, 8'h81, 8'h00, 1'b0);
    queue_pixel(8'h12, 8'h34, 8'h56, 1'b0);
    queue_pixel(8'hab, 8'hcd, 8'hef, 1'b0);
    wait_idle();

    // Raw12 mid-line after a format change, width below minimum
    write_reg(REG_BAYER_PATTERN, PAT_RGGB);
    write_reg(REG_SAMPLE_FORMAT, FMT_RAW12);
    write_reg(REG_LINE_WIDTH, LW_W'(3));
    queue_pixel(8'hf0, 8'h0f, 8'h3c, 1'b0);
    queue_pixel(8'h0f, 8'hf0, 8'hc3, 1'b0);
    queue_pixel(8'h55, 8'haa, 8'h99, 1'b0);
    queue_pixel(8'haa, 8'h55, 8'h66, 1'b0);
    queue_pixel(8'h01, 8'h80, 8'hfe, 1'b0);
    wait_idle();

    // Raw16, width above maximum
    write_reg(REG_BAYER_PATTERN, PAT_GBRG);
    write_reg(REG_SAMPLE_FORMAT, FMT_RAW16);
    write_reg(REG_LINE_WIDTH, '1);
    queue_pixel(8'h11, 8'h22, 8'h33, 1'b0);
    queue_pixel(8'h44, 8'h55, 8'h66, 1'b0);
    queue_pixel(8'h77, 8'h88, 8'h99, 1'b0);
    wait_idle();

    // Width lowered below the current column; unmapped index ignored
    write_reg(REG_LINE_WIDTH, LW_W'(2));
    write_reg(REG_UNUSED, '1);
    write_reg(REG_BAYER_PATTERN, PAT_BGGR);
    queue_pixel(8'hde, 8'had, 8'hbe, 1'b0);
    queue_pixel(8'hef, 8'hca, 8'hfe, 1'b0);
    queue_pixel(8'hba, 8'hbe, 8'h00, 1'b0);
    wait_idle();

    // Random phases: new settings, then a run of raster pixels
    for (int ph = 0; ph < 12; ph++) begin
      no_idle = (ph == 5);
      write_reg(REG_BAYER_PATTERN, LW_W'($urandom_range(0, (1 << LW_W) - 1)));
      write_reg(REG_SAMPLE_FORMAT, LW_W'($urandom_range(0, (1 << LW_W) - 1)));
      case ($urandom_range(0, 9))
        0:       write_reg(REG_LINE_WIDTH, LW_W'($urandom_range(0, 3)));
        1:       write_reg(REG_LINE_WIDTH, LW_W'(MAX_LINE_WIDTH));
        2:       write_reg(REG_LINE_WIDTH, LW_W'($urandom_range(MAX_LINE_WIDTH + 1,
                                                                (1 << LW_W) - 1)));
        default: write_reg(REG_LINE_WIDTH, LW_W'($urandom_range(4, 24)));
      endcase
      n_items = $urandom_range(80, 104);
      for (int i = 0; i < n_items; i++)
        queue_pixel(8'($urandom), 8'($urandom), 8'($urandom),
                    $urandom_range(0, 99) < 3);
      wait_idle();
    end
    no_idle = 1'b0;

    wait_idle();
    repeat (8) @(posedge clk);
    if (errors == 0 && expected_bytes.size() == 0) begin
      $display("bayer_mosaic_raw_packer regression: pass");
    end else begin
      $display("bayer_mosaic_raw_packer regression: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/brp_pkg.sv
rtl/core/brp_in_reg.sv
rtl/core/brp_pack.sv
rtl/core/brp_out_ser.sv
rtl/core/bayer_mosaic_raw_packer.sv
sim/testbench.sv
